FILE: sv/avfe_pkg.sv
// ============================================================================
// avfe_pkg
// Shared constants, item/frame structs and sequencer states for the
// vector-predicted ADPCM frame encoder.
// ============================================================================
package avfe_pkg;

    localparam int FRAME_SAMPLES = 16;
    localparam int TAPS          = 8;
    localparam int STORE_DEPTH   = 256;
    localparam int COEF_FRAC     = 11;
    localparam int SHIFT_LIMIT   = 12;
    localparam int RES_MAX       = 7;
    localparam int RES_MIN       = -8;
    localparam int FRAME_BYTES   = 9;

    // item kinds
    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] sample;
        logic [3:0]  predictor;
        logic [7:0]  coef_index;
        logic [15:0] coef_value;
    } item_t;

    // encoded frame: body byte m holds the nibbles of samples 2m and 2m+1
    typedef struct packed {
        logic [63:0] body;
        logic [3:0]  shift;
        logic [3:0]  predictor;
    } frame_t;

    typedef struct packed {
        logic idle;
        logic frame_end;
        logic done;
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_P1_START,
        ST_P1_VEC,
        ST_P1_FILL,
        ST_P1_INIT,
        ST_P1_RES,
        ST_P1_TRI,
        ST_SRCH,
        ST_P2_START,
        ST_P2_VEC,
        ST_P2_INIT,
        ST_P2_RA,
        ST_P2_RB,
        ST_P2_RC,
        ST_P2_SQ,
        ST_P2_TRI,
        ST_P2_CMP,
        ST_DONE
    } state_t;

endpackage

FILE: sv/adpcm_vector_frame_encoder.sv
// ============================================================================
// adpcm_vector_frame_encoder
// Second-order vector-predicted 4-bit ADPCM frame encoder: codebook writes,
// 16-sample frames, nine output bytes per frame.
// ============================================================================
//
//   channel  dir  payload
//   -------  ---  ---------------------------------------------------------
//   s_*      in   tuser: op; tdata: sample, predictor, coef_index, coef_value
//   m_*      out  tdata: out_byte; tlast: last byte of a frame
//
// Codebook writes and samples 1..15 are taken while the engine is idle. The 16th
// sample starts the encode, whose length is set by the single shared multiplier
// doing every 64-bit multiply-accumulate. s_tready stays low during the encode
// and, for any item, while the next sample would be the 16th and a frame is
// still being sent. Reset clears the history, sample count and predictor; the
// codebook is not cleared.
//
module adpcm_vector_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample[15:0], predictor[19:16],
                                   // coef_index[27:20], coef_value[43:28], zero
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);

    avfe_pkg::item_t   item;
    avfe_pkg::status_t status;
    avfe_pkg::frame_t  frame;
    logic              in_fire;
    logic [71:0]       out_reg;
    logic [3:0]        out_cnt_reg;

    assign item.op         = s_tuser;
    assign item.sample     = s_tdata[15:0];
    assign item.predictor  = s_tdata[19:16];
    assign item.coef_index = s_tdata[27:20];
    assign item.coef_value = s_tdata[43:28];

    assign s_tready = status.idle && !(out_cnt_reg != 4'd0 && status.frame_end);
    assign in_fire  = s_tvalid && s_tready;

    avfe_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .item    (item),
        .status  (status),
        .frame   (frame)
    );

    // output byte shifter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else if (status.done)
        begin
            out_cnt_reg <= 4'(avfe_pkg::FRAME_BYTES);
        end
        else if (m_tvalid && m_tready)
        begin
            out_cnt_reg <= out_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
            out_reg <= {frame.body, frame.shift, frame.predictor};
        else if (m_tvalid && m_tready)
            out_reg <= {8'h0, out_reg[71:8]};
    end

    assign m_tvalid = (out_cnt_reg != 4'd0);
    assign m_tdata  = out_reg[7:0];
    assign m_tlast  = (out_cnt_reg == 4'd1);

endmodule

FILE: sv/avfe_mult.sv
// ============================================================================
// avfe_mult
// Shared signed 33x33 multiplier with a registered product.
// ============================================================================
module avfe_mult (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] product
);

    logic signed [65:0] product_reg;

    // one product per cycle, available on the next cycle
    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

FILE: sv/avfe_engine.sv
// ============================================================================
// avfe_engine
// Codebook store, frame buffer and the sequencer that encodes one frame
// using the shared multiplier for every product.
// ============================================================================
module avfe_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  avfe_pkg::item_t  item,
    output avfe_pkg::status_t status,
    output avfe_pkg::frame_t frame
);

    localparam logic signed [63:0] RMAX = 64'(avfe_pkg::RES_MAX);
    localparam logic signed [63:0] RMIN = 64'(avfe_pkg::RES_MIN);
    localparam logic [3:0]         SMAX = 4'(avfe_pkg::SHIFT_LIMIT);

    avfe_pkg::state_t state_reg, state_next;

    // storage
    logic [15:0]        mem [avfe_pkg::STORE_DEPTH];
    logic [15:0]        rd_data_reg;
    logic [15:0]        fb_reg [avfe_pkg::FRAME_SAMPLES];
    logic [15:0]        coef_reg [2*avfe_pkg::TAPS];
    logic signed [63:0] acc_reg [avfe_pkg::TAPS];
    logic [3:0]         nib_reg [avfe_pkg::FRAME_SAMPLES];
    logic [3:0]         best_nib_reg [avfe_pkg::FRAME_SAMPLES];

    // control state
    logic [3:0]  count_reg;
    logic [3:0]  pred_reg;
    logic [31:0] hist_old_reg, hist_new_reg;
    logic [4:0]  ld_cnt_reg;
    logic [2:0]  i_reg, j_reg;
    logic        t_reg, vec_reg, first_reg;
    logic [1:0]  ph_reg;
    logic [3:0]  shift_reg, sh_reg, hi_reg, best_shift_reg;

    // datapath registers
    logic signed [63:0] s0_reg, s1_reg, s_reg, mn_reg, mx_reg, a_reg;
    logic [63:0]        lo_reg, err_reg, best_err_reg;
    logic [15:0]        x_reg;
    logic [3:0]         r_reg;
    logic [31:0]        best_old_reg, best_new_reg;

    // sequencer controls
    logic               mac_sub;
    logic [2:0]         mac_k;
    logic [3:0]         cidx;
    logic [63:0]        mac_a;
    logic signed [32:0] mult_a, mult_b;
    logic signed [65:0] mult_p;
    logic [2:0]         acc_idx;
    logic [3:0]         fb_idx;
    logic               is_mac;

    // shared combinational values
    logic signed [63:0] acc_rd, res_s, diff, r64;
    logic [15:0]        x_rd;
    logic [63:0]        prod, mac_sum;
    logic signed [15:0] q16;
    logic [31:0]        qd32;
    logic signed [32:0] d33;
    logic [64:0]        err_sum;
    logic               range_bad, tri_end;
    logic [3:0]         r_next;

    avfe_mult u_mult (
        .clk     (clk),
        .a       (mult_a),
        .b       (mult_b),
        .product (mult_p)
    );

    // codebook memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_fire && item.op == avfe_pkg::OP_COEF)
        begin
            mem[item.coef_index] <= item.coef_value;
        end
        rd_data_reg <= mem[{pred_reg, ld_cnt_reg[3:0]}];
    end

    assign acc_idx = is_mac ? mac_k : i_reg;
    assign fb_idx  = {vec_reg, i_reg};
    assign acc_rd  = acc_reg[acc_idx];
    assign x_rd    = fb_reg[fb_idx];
    assign res_s   = acc_rd >>> avfe_pkg::COEF_FRAC;
    assign tri_end = (j_reg == 3'd6 - i_reg);
    assign range_bad = (mn_reg < RMIN) || (mx_reg > RMAX);

    // multiply-accumulate: low half product plus high half product << 32
    assign prod    = lo_reg + {mult_p[31:0], 32'h0};
    assign mac_sum = mac_sub ? 64'(acc_rd - prod) : 64'(acc_rd + prod);

    // residual quantization and decoder reconstruction
    assign diff = {{48{x_reg[15]}}, x_reg} - a_reg;
    assign r64  = diff >>> sh_reg;
    always_comb
    begin
        if (r64 > RMAX)
            r_next = 4'(avfe_pkg::RES_MAX);
        else if (r64 < RMIN)
            r_next = 4'(avfe_pkg::RES_MIN);
        else
            r_next = r64[3:0];
    end
    assign q16     = $signed({{12{r_reg[3]}}, r_reg}) <<< sh_reg;
    assign qd32    = a_reg[31:0] + {{16{q16[15]}}, q16};
    assign d33     = {{17{x_reg[15]}}, x_reg} - {qd32[31], qd32};
    assign err_sum = {1'b0, err_reg} + {1'b0, mult_p[63:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            avfe_pkg::ST_IDLE:
                if (in_fire && item.op == avfe_pkg::OP_SAMPLE && count_reg == 4'hF)
                    state_next = avfe_pkg::ST_LOAD;
            avfe_pkg::ST_LOAD:
                if (ld_cnt_reg == 5'd16)
                    state_next = avfe_pkg::ST_P1_START;
            avfe_pkg::ST_P1_START:
                state_next = avfe_pkg::ST_P1_VEC;
            avfe_pkg::ST_P1_VEC:
                state_next = avfe_pkg::ST_P1_FILL;
            avfe_pkg::ST_P1_FILL:
                if (i_reg == 3'd7)
                    state_next = avfe_pkg::ST_P1_INIT;
            avfe_pkg::ST_P1_INIT:
                if (ph_reg == 2'd2 && t_reg && i_reg == 3'd7)
                    state_next = avfe_pkg::ST_P1_RES;
            avfe_pkg::ST_P1_RES:
                if (i_reg != 3'd7)
                    state_next = avfe_pkg::ST_P1_TRI;
                else if (vec_reg)
                    state_next = avfe_pkg::ST_SRCH;
                else
                    state_next = avfe_pkg::ST_P1_VEC;
            avfe_pkg::ST_P1_TRI:
                if (ph_reg == 2'd2 && tri_end)
                    state_next = avfe_pkg::ST_P1_RES;
            avfe_pkg::ST_SRCH:
                if (!(shift_reg < SMAX && range_bad))
                    state_next = avfe_pkg::ST_P2_START;
            avfe_pkg::ST_P2_START:
                state_next = avfe_pkg::ST_P2_VEC;
            avfe_pkg::ST_P2_VEC:
                state_next = avfe_pkg::ST_P2_INIT;
            avfe_pkg::ST_P2_INIT:
                if (ph_reg == 2'd2 && t_reg && i_reg == 3'd7)
                    state_next = avfe_pkg::ST_P2_RA;
            avfe_pkg::ST_P2_RA:
                state_next = avfe_pkg::ST_P2_RB;
            avfe_pkg::ST_P2_RB:
                state_next = avfe_pkg::ST_P2_RC;
            avfe_pkg::ST_P2_RC:
                state_next = avfe_pkg::ST_P2_SQ;
            avfe_pkg::ST_P2_SQ:
                if (i_reg != 3'd7)
                    state_next = avfe_pkg::ST_P2_TRI;
                else if (vec_reg)
                    state_next = avfe_pkg::ST_P2_CMP;
                else
                    state_next = avfe_pkg::ST_P2_VEC;
            avfe_pkg::ST_P2_TRI:
                if (ph_reg == 2'd2 && tri_end)
                    state_next = avfe_pkg::ST_P2_RA;
            avfe_pkg::ST_P2_CMP:
                if (sh_reg == hi_reg)
                    state_next = avfe_pkg::ST_DONE;
                else
                    state_next = avfe_pkg::ST_P2_START;
            avfe_pkg::ST_DONE:
                state_next = avfe_pkg::ST_IDLE;
            default:
                state_next = avfe_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: MAC operand selection and multiplier inputs
    always_comb
    begin
        is_mac  = 1'b0;
        mac_sub = 1'b0;
        mac_k   = i_reg;
        cidx    = {t_reg, i_reg};
        mac_a   = t_reg ? s1_reg : s0_reg;
        mult_a  = '0;
        mult_b  = '0;
        status  = '0;
        case (state_reg)
            avfe_pkg::ST_IDLE:
                status.idle = 1'b1;
            avfe_pkg::ST_P1_INIT:
            begin
                is_mac  = 1'b1;
                mac_sub = 1'b1;
            end
            avfe_pkg::ST_P1_TRI:
            begin
                is_mac  = 1'b1;
                mac_sub = 1'b1;
                mac_k   = i_reg + 3'd1 + j_reg;
                cidx    = {1'b1, j_reg};
                mac_a   = s_reg;
            end
            avfe_pkg::ST_P2_INIT:
                is_mac = 1'b1;
            avfe_pkg::ST_P2_TRI:
            begin
                is_mac = 1'b1;
                mac_k  = i_reg + 3'd1 + j_reg;
                cidx   = {1'b1, j_reg};
                mac_a  = s_reg;
            end
            avfe_pkg::ST_P2_RC:
            begin
                mult_a = d33;
                mult_b = d33;
            end
            avfe_pkg::ST_DONE:
                status.done = 1'b1;
            default:
                status.idle = 1'b0;
        endcase
        if (is_mac)
        begin
            mult_b = {{17{coef_reg[cidx][15]}}, coef_reg[cidx]};
            if (ph_reg == 2'd0)
                mult_a = {1'b0, mac_a[31:0]};
            else
                mult_a = {mac_a[63], mac_a[63:32]};
        end
        status.frame_end = (count_reg == 4'hF);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= avfe_pkg::ST_IDLE;
            count_reg    <= '0;
            pred_reg     <= '0;
            hist_old_reg <= '0;
            hist_new_reg <= '0;
            ld_cnt_reg   <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            t_reg        <= 1'b0;
            vec_reg      <= 1'b0;
            first_reg    <= 1'b0;
            ph_reg       <= '0;
            shift_reg    <= '0;
            sh_reg       <= '0;
            hi_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= (is_mac && ph_reg != 2'd2) ? ph_reg + 2'd1 : 2'd0;
            case (state_reg)
                avfe_pkg::ST_IDLE:
                begin
                    ld_cnt_reg <= '0;
                    if (in_fire && item.op == avfe_pkg::OP_SAMPLE)
                    begin
                        if (count_reg == 4'h0)
                            pred_reg <= item.predictor;
                        count_reg <= count_reg + 4'd1;
                    end
                end
                avfe_pkg::ST_LOAD:
                    ld_cnt_reg <= ld_cnt_reg + 5'd1;
                avfe_pkg::ST_P1_START:
                begin
                    vec_reg   <= 1'b0;
                    shift_reg <= '0;
                end
                avfe_pkg::ST_P1_VEC, avfe_pkg::ST_P2_VEC:
                begin
                    i_reg <= '0;
                    t_reg <= 1'b0;
                end
                avfe_pkg::ST_P1_FILL:
                    i_reg <= i_reg + 3'd1;
                avfe_pkg::ST_P1_INIT, avfe_pkg::ST_P2_INIT:
                    if (ph_reg == 2'd2)
                    begin
                        t_reg <= ~t_reg;
                        if (t_reg)
                            i_reg <= i_reg + 3'd1;
                    end
                avfe_pkg::ST_P1_RES, avfe_pkg::ST_P2_SQ:
                begin
                    j_reg <= '0;
                    if (i_reg == 3'd7)
                        vec_reg <= 1'b1;
                end
                avfe_pkg::ST_P1_TRI, avfe_pkg::ST_P2_TRI:
                    if (ph_reg == 2'd2)
                    begin
                        if (tri_end)
                        begin
                            i_reg <= i_reg + 3'd1;
                            j_reg <= '0;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                avfe_pkg::ST_SRCH:
                    if (shift_reg < SMAX && range_bad)
                        shift_reg <= shift_reg + 4'd1;
                    else
                    begin
                        sh_reg    <= (shift_reg == 4'd0) ? 4'd0 : shift_reg - 4'd1;
                        hi_reg    <= (shift_reg == SMAX) ? SMAX : shift_reg + 4'd1;
                        first_reg <= 1'b1;
                    end
                avfe_pkg::ST_P2_START:
                    vec_reg <= 1'b0;
                avfe_pkg::ST_P2_CMP:
                begin
                    first_reg <= 1'b0;
                    if (sh_reg != hi_reg)
                        sh_reg <= sh_reg + 4'd1;
                end
                avfe_pkg::ST_DONE:
                begin
                    hist_old_reg <= best_old_reg;
                    hist_new_reg <= best_new_reg;
                end
                default:
                    i_reg <= i_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire && item.op == avfe_pkg::OP_SAMPLE)
            fb_reg[count_reg] <= item.sample;
        if (is_mac && ph_reg == 2'd1)
            lo_reg <= mult_p[63:0];
        if (is_mac && ph_reg == 2'd2)
            acc_reg[mac_k] <= mac_sum;
        case (state_reg)
            avfe_pkg::ST_LOAD:
                if (ld_cnt_reg != 5'd0)
                    coef_reg[ld_cnt_reg[3:0] - 4'd1] <= rd_data_reg;
            avfe_pkg::ST_P1_START:
            begin
                mn_reg <= '0;
                mx_reg <= '0;
            end
            avfe_pkg::ST_P1_VEC:
                if (vec_reg)
                begin
                    s0_reg <= {{48{fb_reg[6][15]}}, fb_reg[6]};
                    s1_reg <= {{48{fb_reg[7][15]}}, fb_reg[7]};
                end
                else
                begin
                    s0_reg <= {{32{hist_old_reg[31]}}, hist_old_reg};
                    s1_reg <= {{32{hist_new_reg[31]}}, hist_new_reg};
                end
            avfe_pkg::ST_P1_FILL:
                acc_reg[i_reg] <= {{37{x_rd[15]}}, x_rd, 11'h0};
            avfe_pkg::ST_P1_RES:
            begin
                s_reg <= res_s;
                if (res_s < mn_reg)
                    mn_reg <= res_s;
                if (res_s > mx_reg)
                    mx_reg <= res_s;
            end
            avfe_pkg::ST_SRCH:
                if (shift_reg < SMAX && range_bad)
                begin
                    mn_reg <= mn_reg >>> 1;
                    mx_reg <= mx_reg >>> 1;
                end
            avfe_pkg::ST_P2_START:
            begin
                s0_reg  <= {{32{hist_old_reg[31]}}, hist_old_reg};
                s1_reg  <= {{32{hist_new_reg[31]}}, hist_new_reg};
                err_reg <= '0;
            end
            avfe_pkg::ST_P2_VEC:
                for (int k = 0; k < avfe_pkg::TAPS; k++)
                begin
                    acc_reg[k] <= '0;
                end
            avfe_pkg::ST_P2_RA:
            begin
                a_reg <= res_s;
                x_reg <= x_rd;
            end
            avfe_pkg::ST_P2_RB:
                r_reg <= r_next;
            avfe_pkg::ST_P2_RC:
            begin
                nib_reg[fb_idx] <= r_reg;
                s_reg  <= {{48{q16[15]}}, q16};
                s0_reg <= s1_reg;
                s1_reg <= {{32{qd32[31]}}, qd32};
            end
            avfe_pkg::ST_P2_SQ:
                err_reg <= err_sum[64] ? '1 : err_sum[63:0];
            avfe_pkg::ST_P2_CMP:
                if (first_reg || err_reg < best_err_reg)
                begin
                    best_err_reg   <= err_reg;
                    best_shift_reg <= sh_reg;
                    best_old_reg   <= s0_reg[31:0];
                    best_new_reg   <= s1_reg[31:0];
                    for (int k = 0; k < avfe_pkg::FRAME_SAMPLES; k++)
                    begin
                        best_nib_reg[k] <= nib_reg[k];
                    end
                end
            default:
                x_reg <= x_reg;
        endcase
    end

    // frame bytes from the chosen encoding
    always_comb
    begin
        frame.shift     = best_shift_reg;
        frame.predictor = pred_reg;
        for (int m = 0; m < 8; m++)
        begin
            frame.body[8*m +: 8] = {best_nib_reg[2*m], best_nib_reg[2*m+1]};
        end
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: adpcm_vector_frame_encoder bench
// Loads codebook entries, streams 16-sample frames and checks every encoded
// byte against a bit-accurate predictor of the encoder or a typed-in result,
// under random idling, a long output hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    typedef struct {
        logic op;
        int   sample;
        int   pred;
        int   idx;
        int   val;
        int   rep;
        bit   known;     // typed-in result: all-zero frame
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // sample, predictor, coef_index, coef_value, zero
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic        m_tlast;

    // predictor state
    longint      cb_mirror [avfe_pkg::STORE_DEPTH];
    longint      frame_buf [avfe_pkg::FRAME_SAMPLES];
    int          fill_cnt;
    logic [3:0]  frame_pred;
    longint      hist_old;
    longint      hist_new;

    enc_byte_t   frame_bytes_q [$];
    bit [255:0]  coef_written;
    int          fail_cnt;
    int          item_cnt;
    bit          quiet;
    int          hold_cycles;
    dir_row_t    rows [12];

    adpcm_vector_frame_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Encode the buffered frame: residual range pass, search of up to three shifts.
    function automatic void encode_frame(output logic [7:0] bytes [9]);
        longint acc [8];
        longint s0, s1, mn, mx, s, x, a, r, q, d, b_old, b_new;
        longint unsigned err, best_err, ad, sq, sum;
        int shift, lo, hi, sh, best_sh, base;
        logic [3:0] nib [16];
        logic [3:0] best_nib [16];
        base = int'(frame_pred) * 16;
        mn = 0;
        mx = 0;
        best_err = 0;
        best_sh = 0;
        b_old = 0;
        b_new = 0;
        for (int v = 0; v < 2; v++)
        begin
            s0 = v ? frame_buf[6] : hist_old;
            s1 = v ? frame_buf[7] : hist_new;
            for (int i = 0; i < avfe_pkg::TAPS; i++)
                acc[i] = (frame_buf[v*avfe_pkg::TAPS+i] <<< avfe_pkg::COEF_FRAC)
                         - s0 * cb_mirror[base+i]
                         - s1 * cb_mirror[base+avfe_pkg::TAPS+i];
            for (int i = 0; i < avfe_pkg::TAPS; i++)
            begin
                s = acc[i] >>> avfe_pkg::COEF_FRAC;
                if (s < mn) mn = s;
                if (s > mx) mx = s;
                for (int j = 0; j < avfe_pkg::TAPS - 1 - i; j++)
                    acc[i+1+j] -= s * cb_mirror[base+avfe_pkg::TAPS+j];
            end
        end
        shift = 0;
        while (shift < avfe_pkg::SHIFT_LIMIT
               && (mn < avfe_pkg::RES_MIN || mx > avfe_pkg::RES_MAX))
        begin
            mn = mn >>> 1;
            mx = mx >>> 1;
            shift++;
        end
        lo = (shift > 0) ? shift - 1 : 0;
        hi = (shift < avfe_pkg::SHIFT_LIMIT) ? shift + 1 : avfe_pkg::SHIFT_LIMIT;
        for (sh = lo; sh <= hi; sh++)
        begin
            err = 0;
            s0 = hist_old;
            s1 = hist_new;
            for (int v = 0; v < 2; v++)
            begin
                for (int i = 0; i < avfe_pkg::TAPS; i++)
                    acc[i] = s0 * cb_mirror[base+i] + s1 * cb_mirror[base+avfe_pkg::TAPS+i];
                for (int i = 0; i < avfe_pkg::TAPS; i++)
                begin
                    x = frame_buf[v*avfe_pkg::TAPS+i];
                    a = acc[i] >>> avfe_pkg::COEF_FRAC;
                    r = (x - a) >>> sh;
                    if (r > avfe_pkg::RES_MAX) r = avfe_pkg::RES_MAX;
                    else if (r < avfe_pkg::RES_MIN) r = avfe_pkg::RES_MIN;
                    nib[v*avfe_pkg::TAPS+i] = r[3:0];
                    q = r * (longint'(1) << sh);
                    for (int j = 0; j < avfe_pkg::TAPS - 1 - i; j++)
                        acc[i+1+j] += q * cb_mirror[base+avfe_pkg::TAPS+j];
                    q = longint'(int'(q + a));
                    s0 = s1;
                    s1 = q;
                    d = x - q;
                    ad = (d < 0) ? longint'(-d) : d;
                    sq = ad * ad;
                    sum = err + sq;
                    err = (sum < err) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
                end
            end
            // lower shift wins a tie
            if (sh == lo || err < best_err)
            begin
                best_err = err;
                best_sh = sh;
                best_nib = nib;
                b_old = s0;
                b_new = s1;
            end
        end
        hist_old = b_old;
        hist_new = b_new;
        bytes[0] = {best_sh[3:0], frame_pred};
        for (int m = 0; m < 8; m++)
            bytes[m+1] = {best_nib[2*m], best_nib[2*m+1]};
    endfunction

    // Update the predictor with one accepted transfer.
    function automatic void absorb_item(avfe_pkg::item_t it, bit known);
        logic [7:0] bytes [9];
        if (it.op == avfe_pkg::OP_COEF)
        begin
            cb_mirror[it.coef_index] = longint'($signed(it.coef_value));
            return;
        end
        if (fill_cnt == 0)
            frame_pred = it.predictor;
        frame_buf[fill_cnt] = longint'($signed(it.sample));
        fill_cnt = (fill_cnt + 1) % avfe_pkg::FRAME_SAMPLES;
        if (fill_cnt != 0)
            return;
        encode_frame(bytes);
        for (int k = 0; k < avfe_pkg::FRAME_BYTES; k++)
            frame_bytes_q.push_back('{known ? 8'h00 : bytes[k],
                                      k == avfe_pkg::FRAME_BYTES - 1});
    endfunction

    // Offer one item until its transfer completes.
    task automatic send_item(avfe_pkg::item_t it, bit known);
        while (!quiet && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.coef_value, it.coef_index, it.predictor, it.sample};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.op == avfe_pkg::OP_COEF)
            coef_written[it.coef_index] = 1'b1;
        item_cnt++;
        absorb_item(it, known);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    // One random frame, loading the chosen predictor's taps first if needed.
    task automatic gen_frame();
        avfe_pkg::item_t it;
        int p, mode, base_val;
        p = $urandom_range(0, 15);
        mode = $urandom_range(0, 4);
        base_val = $urandom_range(0, 65535) - 32768;
        for (int t = 0; t < 16; t++)
        begin
            if (!coef_written[p*16+t])
            begin
                it = '{avfe_pkg::OP_COEF, 16'($urandom), 4'($urandom), 8'(p*16+t),
                       rand_coef()};
                send_item(it, 1'b0);
            end
        end
        for (int k = 0; k < avfe_pkg::FRAME_SAMPLES; k++)
        begin
            // stray coefficient write, also inside a frame
            if ($urandom_range(0, 99) < 6)
            begin
                it = '{avfe_pkg::OP_COEF, 16'($urandom), 4'($urandom), 8'($urandom),
                       rand_coef()};
                send_item(it, 1'b0);
            end
            it.op = avfe_pkg::OP_SAMPLE;
            case (mode)
                0:       it.sample = 16'($urandom);
                1:       it.sample = 16'($urandom_range(0, 100) - 50);
                2:       it.sample = 16'(base_val + k * 300);
                3:       it.sample = 16'(base_val);
                default: it.sample = 16'(base_val + $urandom_range(0, 2000) - 1000);
            endcase
            it.predictor  = (k == 0) ? 4'(p) : 4'($urandom);
            it.coef_index = 8'($urandom);
            it.coef_value = 16'($urandom);
            send_item(it, 1'b0);
        end
    endtask

    // Output side: random stalls, long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    // Output check against the oldest expected byte.
    always @(posedge clk)
    begin
        enc_byte_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_bytes_q.size() == 0)
            begin
                $error("unexpected out_byte %02h", m_tdata);
                fail_cnt++;
            end
            else
            begin
                e = frame_bytes_q.pop_front();
                if (m_tdata !== e.data)
                begin
                    $error("out_byte: expected %02h actual %02h", e.data, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last: expected %0b actual %0b", e.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        avfe_pkg::item_t it;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = avfe_pkg::OP_COEF;
        fail_cnt    = 0;
        item_cnt    = 0;
        quiet       = 1'b0;
        hold_cycles = 0;
        fill_cnt    = 0;
        frame_pred  = '0;
        hist_old    = 0;
        hist_new    = 0;
        coef_written = '0;
        foreach (cb_mirror[i]) cb_mirror[i] = 0;
        foreach (frame_buf[i]) frame_buf[i] = 0;

        // op, sample, predictor, index, value, repeat, typed result
        rows = '{
            '{avfe_pkg::OP_COEF,        0,  0,   0,      0, 16, 1'b0},
            '{avfe_pkg::OP_SAMPLE,      0,  0,   0,      0, 16, 1'b1},  // all-zero frame
            '{avfe_pkg::OP_COEF,        0,  0, 240,      0, 16, 1'b0},
            '{avfe_pkg::OP_SAMPLE,  32767, 15,   0,      0, 16, 1'b0},  // max shift
            '{avfe_pkg::OP_SAMPLE, -32768, 15, 255,  32767, 16, 1'b0},
            '{avfe_pkg::OP_COEF,        0,  0,  16,  32767,  8, 1'b0},  // extreme taps
            '{avfe_pkg::OP_COEF,        0,  0,  24, -32768,  8, 1'b0},
            '{avfe_pkg::OP_SAMPLE,  12345,  1,   0,      0,  7, 1'b0},  // wide accumulators
            '{avfe_pkg::OP_SAMPLE, -20000,  1,   0,      0,  9, 1'b0},
            '{avfe_pkg::OP_SAMPLE,    100,  0,   0,      0,  8, 1'b0},
            '{avfe_pkg::OP_COEF,        0,  0,   3,   2048,  1, 1'b0},  // write inside a frame
            '{avfe_pkg::OP_SAMPLE,   -100,  9,   0,      0,  8, 1'b0}   // predictor only on 1st
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[r])
        begin
            for (int k = 0; k < rows[r].rep; k++)
            begin
                it.op         = rows[r].op;
                it.sample     = 16'(rows[r].sample);
                it.predictor  = 4'(rows[r].pred);
                it.coef_index = 8'(rows[r].idx
                                   + ((rows[r].op == avfe_pkg::OP_COEF) ? k : 0));
                it.coef_value = 16'(rows[r].val);
                send_item(it, rows[r].known);
            end
        end

        // random frames
        while (item_cnt < 150)
            gen_frame();

        // output held off while frames keep coming
        hold_cycles = 3000;
        repeat (3) gen_frame();

        // sender pause until all bytes are out, then a stretch with no idling
        s_tvalid <= 1'b0;
        wait (frame_bytes_q.size() == 0 && hold_cycles == 0);
        quiet = 1'b1;
        repeat (3) gen_frame();
        quiet = 1'b0;

        while (item_cnt < 420)
            gen_frame();
        s_tvalid <= 1'b0;

        wait (frame_bytes_q.size() == 0);
        repeat (1500) @(posedge clk);
        if (fail_cnt == 0 && frame_bytes_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
